// ===== rtl/tmcl_pkg.sv =====
// Shared types and constants for the texture mip chain layout block.
// No dependencies; used by every module under rtl/.
package tmcl_pkg;

  localparam int MAX_MIPS  = 15;
  localparam int ADDR_BITS = 48;
  localparam int LVL_W     = 4;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BASE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_BASE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BASE_DEPTH  = 3'd2;
  localparam logic [2:0] REG_MIP_COUNT   = 3'd3;
  localparam logic [2:0] REG_FORMAT_KIND = 3'd4;
  localparam logic [2:0] REG_BPP         = 3'd5;
  localparam logic [2:0] REG_SIZE_LIMIT  = 3'd6;

  // format classes
  localparam logic [1:0] FMT_PLAIN   = 2'd0;
  localparam logic [1:0] FMT_BLOCK8  = 2'd1;
  localparam logic [1:0] FMT_BLOCK16 = 2'd2;
  localparam logic [1:0] FMT_PACKED  = 2'd3;

  typedef struct packed {
    logic [14:0] base_width;
    logic [14:0] base_height;
    logic [11:0] base_depth;
    logic [3:0]  mip_count;
    logic [1:0]  format_kind;
    logic [7:0]  bits_per_pixel;
    logic [14:0] size_limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic start;  // item accepted: load extents, maybe restart
    logic mul;    // width times bits per pixel
    logic pitch;  // row bytes, rows, keep decision
    logic slice;  // slice pitch
    logic adv;    // address advance
    logic emit;   // load result register, step to next level
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic last_level;
  } stat_t;

  typedef struct packed {
    logic [11:0]          top_depth;
    logic [14:0]          top_height;
    logic [14:0]          top_width;
    logic [14:0]          skip_count;
    logic [31:0]          slice_pitch;
    logic [18:0]          row_pitch;
    logic [47:0]          data_address;
    logic [LVL_W-1:0]     mip_level;
  } res_t;

endpackage

// ===== rtl/texture_mip_chain_layout_top.sv =====
// Top level of the texture mip chain layout block.
// Depends on tmcl_pkg, tmcl_cfg, tmcl_ctrl and tmcl_dp.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+--------------------------------------
//   slice in | in  | s_tvalid/s_tready  | s_tdata base_address, s_tuser restart
//   level out| out | m_tvalid/m_tready  | m_tdata layout, m_tuser kept, m_tlast
//   config   | in  | psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// Each level passes through five sequencer steps (multiply by bits per pixel,
// pitch, slice multiply, address-advance multiply, result load); the next item
// is accepted only once the final level's result load has returned it to idle.
// Reset is synchronous; it clears the sequencer, running address, skip count
// and top-level extents, and returns the registers to their defaults.
// A stalled m_tready holds the sequencer at the result load; the next item
// may be accepted while the final level still waits in the result register.
module texture_mip_chain_layout_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,  // [47:0] base_address
  input  logic         s_tuser,  // [0] restart
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] mip_level, [51:4] data_address, [70:52] row_pitch,
  // [102:71] slice_pitch, [117:103] skip_count, [132:118] top_width,
  // [147:133] top_height, [159:148] top_depth
  output logic [159:0] m_tdata,
  output logic         m_tuser,  // [0] kept
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  tmcl_pkg::cfg_t  cfg;
  tmcl_pkg::cmd_t  cmd;
  tmcl_pkg::stat_t stat;
  tmcl_pkg::res_t  res;

  tmcl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tmcl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .restart      (s_tuser),
    .base_address (s_tdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .res          (res),
    .res_kept     (m_tuser),
    .res_last     (m_tlast)
  );

  assign m_tdata = res;

  // an accepted item occupies the sequencer for at least one level
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again straight after an item");

  // no new item while a non-final level of the current one is on the output
  a_no_accept_mid_slice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready while a slice is still being laid out");

  // a result load only happens when the result register is free
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result register overwritten");

endmodule

// ===== rtl/tmcl_cfg.sv =====
// Configuration register file on the APB-style port.
// Depends on tmcl_pkg.
module tmcl_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output tmcl_pkg::cfg_t   cfg
);

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_width     <= 15'd1;
      cfg.base_height    <= 15'd1;
      cfg.base_depth     <= 12'd1;
      cfg.mip_count      <= 4'd1;
      cfg.format_kind    <= tmcl_pkg::FMT_PLAIN;
      cfg.bits_per_pixel <= 8'd32;
      cfg.size_limit     <= 15'd0;
    end else if (wr) begin
      unique case (idx)
        tmcl_pkg::REG_BASE_WIDTH:  cfg.base_width     <= pwdata[14:0];
        tmcl_pkg::REG_BASE_HEIGHT: cfg.base_height    <= pwdata[14:0];
        tmcl_pkg::REG_BASE_DEPTH:  cfg.base_depth     <= pwdata[11:0];
        tmcl_pkg::REG_MIP_COUNT:   cfg.mip_count      <= pwdata[3:0];
        tmcl_pkg::REG_FORMAT_KIND: cfg.format_kind    <= pwdata[1:0];
        tmcl_pkg::REG_BPP:         cfg.bits_per_pixel <= pwdata[7:0];
        tmcl_pkg::REG_SIZE_LIMIT:  cfg.size_limit     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tmcl_pkg::REG_BASE_WIDTH:  prdata = {17'd0, cfg.base_width};
      tmcl_pkg::REG_BASE_HEIGHT: prdata = {17'd0, cfg.base_height};
      tmcl_pkg::REG_BASE_DEPTH:  prdata = {20'd0, cfg.base_depth};
      tmcl_pkg::REG_MIP_COUNT:   prdata = {28'd0, cfg.mip_count};
      tmcl_pkg::REG_FORMAT_KIND: prdata = {30'd0, cfg.format_kind};
      tmcl_pkg::REG_BPP:         prdata = {24'd0, cfg.bits_per_pixel};
      tmcl_pkg::REG_SIZE_LIMIT:  prdata = {17'd0, cfg.size_limit};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/tmcl_ctrl.sv =====
// Level sequencer: steps each mip level through the datapath stages.
// Depends on tmcl_pkg.
module tmcl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmcl_pkg::stat_t stat,
  output tmcl_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_PITCH = 3'd2;
  localparam logic [2:0] ST_SLICE = 3'd3;
  localparam logic [2:0] ST_ADV   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PITCH;
      end
      ST_PITCH: begin
        cmd.pitch  = 1'b1;
        state_next = ST_SLICE;
      end
      ST_SLICE: begin
        cmd.slice  = 1'b1;
        state_next = ST_ADV;
      end
      ST_ADV: begin
        cmd.adv    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold here until the result register can take the level
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.last_level ? ST_IDLE : ST_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/tmcl_dp.sv =====
// Datapath: extents, pitch arithmetic, running address, skip and top-level
// tracking, and the result register. Depends on tmcl_pkg.
module tmcl_dp (
  input  logic            clk,
  input  logic            rst,
  input  tmcl_pkg::cfg_t  cfg,
  input  tmcl_pkg::cmd_t  cmd,
  output tmcl_pkg::stat_t stat,
  input  logic            restart,
  input  logic [47:0]     base_address,
  output logic            out_valid,
  input  logic            out_ready,
  output tmcl_pkg::res_t  res,
  output logic            res_kept,
  output logic            res_last
);

  localparam int LW = tmcl_pkg::LVL_W;

  // level state
  logic [14:0] w, h;
  logic [11:0] d;
  logic [LW-1:0] level, count;

  // per-level stage registers
  logic [22:0] bpp_prod;
  logic [19:0] rb;
  logic [14:0] rows;
  logic        keep;
  logic [34:0] bytes;
  logic [46:0] advance;

  // state kept across items
  logic [tmcl_pkg::ADDR_BITS-1:0] run_addr;
  logic [14:0] skipped;
  logic [14:0] first_w, first_h;
  logic [11:0] first_d;
  logic        first_found;

  // pitch stage logic
  logic [15:0] w_p3, h_p3, w_p1;
  logic [23:0] plain_sum;
  logic [19:0] rb_c;
  logic [14:0] rows_c;
  logic        keep_c;
  logic [LW-1:0] count_c;

  // emit stage logic
  logic [14:0] skipped_new, first_w_new, first_h_new;
  logic [11:0] first_d_new;
  logic        first_found_new;

  assign w_p3      = {1'b0, w} + 16'd3;
  assign h_p3      = {1'b0, h} + 16'd3;
  assign w_p1      = {1'b0, w} + 16'd1;
  assign plain_sum = {1'b0, bpp_prod} + 24'd7;

  always_comb begin
    unique case (cfg.format_kind)
      tmcl_pkg::FMT_BLOCK8: begin
        rb_c   = {3'd0, w_p3[15:2], 3'd0};
        rows_c = {1'b0, h_p3[15:2]};
      end
      tmcl_pkg::FMT_BLOCK16: begin
        rb_c   = {2'd0, w_p3[15:2], 4'd0};
        rows_c = {1'b0, h_p3[15:2]};
      end
      tmcl_pkg::FMT_PACKED: begin
        rb_c   = {3'd0, w_p1[15:1], 2'd0};
        rows_c = h;
      end
      default: begin
        rb_c   = plain_sum[22:3];
        rows_c = h;
      end
    endcase
  end

  assign keep_c = (count <= LW'(1)) || (cfg.size_limit == 15'd0) ||
                  ((w <= cfg.size_limit) && (h <= cfg.size_limit) &&
                   ({3'd0, d} <= cfg.size_limit));

  // zero means one level, anything above the limit is clamped
  always_comb begin
    priority if (cfg.mip_count == 4'd0) begin
      count_c = LW'(1);
    end else if ({1'b0, cfg.mip_count} > 5'(tmcl_pkg::MAX_MIPS)) begin
      count_c = LW'(tmcl_pkg::MAX_MIPS);
    end else begin
      count_c = LW'(cfg.mip_count);
    end
  end

  always_comb begin
    skipped_new     = skipped;
    first_w_new     = first_w;
    first_h_new     = first_h;
    first_d_new     = first_d;
    first_found_new = first_found;
    if (keep) begin
      if (!first_found) begin
        first_found_new = 1'b1;
        first_w_new     = w;
        first_h_new     = h;
        first_d_new     = d;
      end
    end else if (skipped != 15'h7FFF) begin
      skipped_new = skipped + 15'd1;
    end
  end

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.last_level = (level == count - LW'(1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w     <= cfg.base_width;
      h     <= cfg.base_height;
      d     <= cfg.base_depth;
      level <= '0;
      count <= count_c;
    end else if (cmd.emit) begin
      w     <= (w[14:1] == 14'd0) ? 15'd1 : {1'b0, w[14:1]};
      h     <= (h[14:1] == 14'd0) ? 15'd1 : {1'b0, h[14:1]};
      d     <= (d[11:1] == 11'd0) ? 12'd1 : {1'b0, d[11:1]};
      level <= level + LW'(1);
    end
    if (cmd.mul) begin
      bpp_prod <= 23'(w) * 23'(cfg.bits_per_pixel);
    end
    if (cmd.pitch) begin
      rb   <= rb_c;
      rows <= rows_c;
      keep <= keep_c;
    end
    if (cmd.slice) begin
      bytes <= 35'(rb) * 35'(rows);
    end
    if (cmd.adv) begin
      advance <= 47'(bytes) * 47'(d);
    end
    if (cmd.emit) begin
      res.mip_level    <= level;
      res.data_address <= run_addr[47:0];
      res.row_pitch    <= rb[18:0];
      res.slice_pitch  <= bytes[31:0];
      res.skip_count   <= skipped_new;
      res.top_width    <= first_w_new;
      res.top_height   <= first_h_new;
      res.top_depth    <= first_d_new;
      res_kept         <= keep;
      res_last         <= stat.last_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_addr    <= '0;
      skipped     <= '0;
      first_w     <= '0;
      first_h     <= '0;
      first_d     <= '0;
      first_found <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.start && restart) begin
        run_addr    <= tmcl_pkg::ADDR_BITS'(base_address);
        skipped     <= '0;
        first_w     <= '0;
        first_h     <= '0;
        first_d     <= '0;
        first_found <= 1'b0;
      end else if (cmd.emit) begin
        run_addr    <= run_addr + tmcl_pkg::ADDR_BITS'(advance);
        skipped     <= skipped_new;
        first_w     <= first_w_new;
        first_h     <= first_h_new;
        first_d     <= first_d_new;
        first_found <= first_found_new;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
